// ===== hw/rtl/rtpfu_pkg.sv =====
// Shared types and constants of the H.264 RTP FU-A packetizer.
package rtpfu_pkg;

   localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
   localparam logic [4:0] FU_A_TYPE        = 5'd28;
   localparam logic [7:0] NRI_F_MASK       = 8'hE0;
   localparam logic [7:0] NAL_TYPE_MASK    = 8'h1F;
   localparam logic [7:0] FU_START_BIT     = 8'h80;
   localparam logic [7:0] FU_END_BIT       = 8'h40;
   localparam logic [15:0] FU_OVERHEAD     = 16'd14;

   localparam logic [15:0] RESET_THRESHOLD = 16'd1400;
   localparam logic [15:0] RESET_MAX_PKT   = 16'd1400;
   localparam logic [6:0]  RESET_PT        = 7'h60;

   // configuration register indexes
   localparam logic [1:0] CSR_FRAG_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_MAX_PACKET     = 2'd1;
   localparam logic [1:0] CSR_PAYLOAD_TYPE   = 2'd2;
   localparam logic [1:0] CSR_SSRC           = 2'd3;

   // byte positions inside one emitted run of the back end
   localparam logic [3:0] STEP_HDR_FIRST = 4'd0;
   localparam logic [3:0] STEP_PT        = 4'd1;
   localparam logic [3:0] STEP_SEQ_HI    = 4'd2;
   localparam logic [3:0] STEP_SEQ_LO    = 4'd3;
   localparam logic [3:0] STEP_TS_3      = 4'd4;
   localparam logic [3:0] STEP_TS_2      = 4'd5;
   localparam logic [3:0] STEP_TS_1      = 4'd6;
   localparam logic [3:0] STEP_TS_0      = 4'd7;
   localparam logic [3:0] STEP_SSRC_3    = 4'd8;
   localparam logic [3:0] STEP_SSRC_2    = 4'd9;
   localparam logic [3:0] STEP_SSRC_1    = 4'd10;
   localparam logic [3:0] STEP_SSRC_0    = 4'd11;
   localparam logic [3:0] STEP_FU_IND    = 4'd12;
   localparam logic [3:0] STEP_FU_HDR    = 4'd13;
   localparam logic [3:0] STEP_PAYLOAD   = 4'd14;

   typedef enum logic [1:0] {
      KIND_PLAIN  = 2'd0,  // payload byte only
      KIND_SINGLE = 2'd1,  // RTP header, then the byte
      KIND_FU     = 2'd2   // RTP header, FU indicator, FU header, then the byte
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic        is_end;
      logic [15:0] seq;
      logic [31:0] ts;
      logic [7:0]  fu_ind;
      logic [7:0]  fu_hdr;
   } cmd_type;

   typedef struct packed {
      logic [15:0] fragment_threshold;
      logic [15:0] max_packet_bytes;
      logic [6:0]  payload_type;
      logic [31:0] ssrc_value;
   } csr_type;

endpackage

// ===== hw/rtl/rtpfu_if.sv =====
// Channel interfaces: NAL byte input and RTP byte output.
interface rtpfu_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  nal_byte;
   logic        first_of_nal;
   logic        last_of_nal;
   logic [15:0] nal_length;
   logic [31:0] time_stamp;

   modport source (output valid, nal_byte, first_of_nal, last_of_nal, nal_length,
                   time_stamp, input ready);
   modport sink   (input valid, nal_byte, first_of_nal, last_of_nal, nal_length,
                   time_stamp, output ready);
endinterface

interface rtpfu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       packet_end;

   modport source (output valid, out_byte, packet_end, input ready);
   modport sink   (input valid, out_byte, packet_end, output ready);
endinterface

// ===== hw/rtl/rtpfu_front.sv =====
// Front end: tracks NAL and fragment state and turns each byte to be sent into a command.
module rtpfu_front #(
   parameter int LENGTH_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   rtpfu_req_if.sink            req_chan,
   input  rtpfu_pkg::csr_type   csr,
   input  logic                 q_full,
   output logic                 q_push,
   output rtpfu_pkg::cmd_type   q_cmd
);

   logic [15:0]            seq_ff, seq_in;
   logic                   fmode_ff, fmode_in;
   logic [7:0]             hdr_ff, hdr_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [15:0]            bif_ff, bif_in;
   logic                   ffp_ff, ffp_in;
   logic [31:0]            ts_ff, ts_in;

   logic                   accept;
   logic [LENGTH_BITS-1:0] len_raw, len_fix, len_m1;
   logic [15:0]            pl, bif_inc, seq_next;
   logic                   nal_end, fmode_new;
   logic [7:0]             fu_hdr;

   assign accept   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !q_full;
   assign len_raw  = req_chan.nal_length[LENGTH_BITS-1:0];
   assign len_fix  = (len_raw == '0) ? LENGTH_BITS'(1) : len_raw;
   assign len_m1   = len_fix - LENGTH_BITS'(1);
   assign fmode_new = 16'(len_fix) >= csr.fragment_threshold;
   assign pl       = (csr.max_packet_bytes > rtpfu_pkg::FU_OVERHEAD) ?
                     (csr.max_packet_bytes - rtpfu_pkg::FU_OVERHEAD) : 16'd1;
   assign bif_inc  = bif_ff + 16'd1;
   assign seq_next = seq_ff + 16'd1;

   always_comb begin
      seq_in   = seq_ff;
      fmode_in = fmode_ff;
      hdr_in   = hdr_ff;
      rem_in   = rem_ff;
      bif_in   = bif_ff;
      ffp_in   = ffp_ff;
      ts_in    = ts_ff;
      q_push   = 1'b0;
      nal_end  = 1'b0;
      fu_hdr   = hdr_ff & rtpfu_pkg::NAL_TYPE_MASK;
      q_cmd.kind   = rtpfu_pkg::KIND_PLAIN;
      q_cmd.data   = req_chan.nal_byte;
      q_cmd.is_end = 1'b0;
      q_cmd.seq    = seq_next;
      q_cmd.ts     = ts_ff;
      q_cmd.fu_ind = (hdr_ff & rtpfu_pkg::NRI_F_MASK) | {3'b000, rtpfu_pkg::FU_A_TYPE};
      q_cmd.fu_hdr = fu_hdr;
      if (req_chan.first_of_nal) begin
         nal_end  = (len_m1 == '0) || req_chan.last_of_nal;
         fmode_in = fmode_new;
         hdr_in   = req_chan.nal_byte;
         ts_in    = req_chan.time_stamp;
         rem_in   = nal_end ? '0 : len_m1;
         bif_in   = 16'd0;
         ffp_in   = 1'b1;
         q_cmd.kind   = rtpfu_pkg::KIND_SINGLE;
         q_cmd.ts     = req_chan.time_stamp;
         q_cmd.is_end = nal_end;
         if (!fmode_new) begin
            q_push = accept;
            seq_in = seq_next;
         end
      end else if (rem_ff != '0) begin
         nal_end      = (rem_ff == LENGTH_BITS'(1)) || req_chan.last_of_nal;
         rem_in       = nal_end ? '0 : (rem_ff - LENGTH_BITS'(1));
         q_push       = accept;
         q_cmd.is_end = nal_end;
         if (fmode_ff) begin
            if (bif_ff == 16'd0) begin
               if (ffp_ff) fu_hdr = fu_hdr | rtpfu_pkg::FU_START_BIT;
               if (16'(rem_ff) <= pl) fu_hdr = fu_hdr | rtpfu_pkg::FU_END_BIT;
               q_cmd.kind   = rtpfu_pkg::KIND_FU;
               q_cmd.fu_hdr = fu_hdr;
               ffp_in = 1'b0;
               seq_in = seq_next;
            end
            if (bif_inc >= pl || nal_end) begin
               bif_in       = 16'd0;
               q_cmd.is_end = 1'b1;
            end else begin
               bif_in = bif_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= '0;
         fmode_ff <= 1'b0;
         hdr_ff   <= '0;
         rem_ff   <= '0;
         bif_ff   <= '0;
         ffp_ff   <= 1'b1;
         ts_ff    <= '0;
      end else if (accept) begin
         seq_ff   <= seq_in;
         fmode_ff <= fmode_in;
         hdr_ff   <= hdr_in;
         rem_ff   <= rem_in;
         bif_ff   <= bif_in;
         ffp_ff   <= ffp_in;
         ts_ff    <= ts_in;
      end
   end

endmodule

// ===== hw/rtl/rtpfu_queue.sv =====
// Small command queue between the front and back ends.
module rtpfu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rtpfu_pkg::cmd_type push_cmd,
   input  logic               pop,
   output rtpfu_pkg::cmd_type head_cmd,
   output logic               full,
   output logic               empty
);

   localparam int DEPTH = 4;
   localparam int PTR_BITS = $clog2(DEPTH);

   rtpfu_pkg::cmd_type     mem_ff [DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]      count_ff;

   assign full     = (count_ff == (PTR_BITS+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         if (push && !pop) count_ff <= count_ff + (PTR_BITS+1)'(1);
         else if (pop && !push) count_ff <= count_ff - (PTR_BITS+1)'(1);
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_BITS+1)'(DEPTH)) else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("pop from empty queue");

endmodule

// ===== hw/rtl/rtpfu_back.sv =====
// Back end: expands each command into the RTP header and FU bytes its kind asks for, then the payload byte.
module rtpfu_back (
   input  logic               clock,
   input  logic               reset,
   input  rtpfu_pkg::csr_type csr,
   input  rtpfu_pkg::cmd_type head_cmd,
   input  logic               empty,
   output logic               pop,
   rtpfu_rsp_if.source        rsp_chan
);

   logic       busy_ff;
   logic [3:0] step_ff;
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_end_ff;

   logic       load, emit;
   logic [3:0] step, step_next;
   logic [7:0] byte_out;
   logic       end_out;

   assign load = !rsp_valid_ff || rsp_chan.ready;
   assign emit = load && !empty;
   assign pop  = emit && (step == rtpfu_pkg::STEP_PAYLOAD);

   always_comb begin
      if (busy_ff) step = step_ff;
      else if (head_cmd.kind == rtpfu_pkg::KIND_PLAIN) step = rtpfu_pkg::STEP_PAYLOAD;
      else step = rtpfu_pkg::STEP_HDR_FIRST;
   end

   always_comb begin
      if (step == rtpfu_pkg::STEP_SSRC_0 && head_cmd.kind == rtpfu_pkg::KIND_SINGLE)
         step_next = rtpfu_pkg::STEP_PAYLOAD;
      else
         step_next = step + 4'd1;
   end

   always_comb begin
      end_out = 1'b0;
      unique case (step)
         rtpfu_pkg::STEP_HDR_FIRST: byte_out = rtpfu_pkg::RTP_VERSION_BYTE;
         rtpfu_pkg::STEP_PT:        byte_out = {1'b0, csr.payload_type};
         rtpfu_pkg::STEP_SEQ_HI:    byte_out = head_cmd.seq[15:8];
         rtpfu_pkg::STEP_SEQ_LO:    byte_out = head_cmd.seq[7:0];
         rtpfu_pkg::STEP_TS_3:      byte_out = head_cmd.ts[31:24];
         rtpfu_pkg::STEP_TS_2:      byte_out = head_cmd.ts[23:16];
         rtpfu_pkg::STEP_TS_1:      byte_out = head_cmd.ts[15:8];
         rtpfu_pkg::STEP_TS_0:      byte_out = head_cmd.ts[7:0];
         rtpfu_pkg::STEP_SSRC_3:    byte_out = csr.ssrc_value[31:24];
         rtpfu_pkg::STEP_SSRC_2:    byte_out = csr.ssrc_value[23:16];
         rtpfu_pkg::STEP_SSRC_1:    byte_out = csr.ssrc_value[15:8];
         rtpfu_pkg::STEP_SSRC_0:    byte_out = csr.ssrc_value[7:0];
         rtpfu_pkg::STEP_FU_IND:    byte_out = head_cmd.fu_ind;
         rtpfu_pkg::STEP_FU_HDR:    byte_out = head_cmd.fu_hdr;
         default: begin
            byte_out = head_cmd.data;
            end_out  = head_cmd.is_end;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= rtpfu_pkg::STEP_HDR_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) rsp_valid_ff <= !empty;
         if (emit) begin
            busy_ff <= !pop;
            step_ff <= step_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff <= byte_out;
         rsp_end_ff  <= end_out;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_byte   = rsp_byte_ff;
   assign rsp_chan.packet_end = rsp_end_ff;

   // a partly sent command must stay at the head of the queue
   a_busy_head: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (!empty && step_ff != rtpfu_pkg::STEP_HDR_FIRST
                   && step_ff != 4'd15)) else $error("back end lost its command");

endmodule

// ===== hw/rtl/h264_rtp_fua_packetizer.sv =====
// Top level of the H.264 RTP packetizer (single NAL and FU-A modes).
//
//  channel   | dir | handshake       | payload
//  req_chan  | in  | valid / ready   | nal_byte, first_of_nal, last_of_nal, nal_length, time_stamp
//  rsp_chan  | out | valid / ready   | out_byte, packet_end
//  csr_*     | in  | write enable    | csr_index (2 bits), csr_write_data (32 bits)
//
// One RTP byte leaves per cycle while the output is ready; a byte that opens a packet is
// preceded by the RTP header, plus FU indicator and FU header in FU-A, from the back end serializer.
// A 4-entry command queue lets input bytes keep arriving while header bytes go out.
// Input ready drops only when the queue is full; output stalls hold the output register.
// Synchronous active-high reset; no clearing pass, the block takes bytes right after reset.
module h264_rtp_fua_packetizer #(
   parameter int LENGTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   rtpfu_req_if.sink   req_chan,
   rtpfu_rsp_if.source rsp_chan,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   rtpfu_pkg::csr_type csr_ff;
   rtpfu_pkg::cmd_type push_cmd, head_cmd;
   logic               q_push, q_pop, q_full, q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.fragment_threshold <= rtpfu_pkg::RESET_THRESHOLD;
         csr_ff.max_packet_bytes   <= rtpfu_pkg::RESET_MAX_PKT;
         csr_ff.payload_type       <= rtpfu_pkg::RESET_PT;
         csr_ff.ssrc_value         <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            rtpfu_pkg::CSR_FRAG_THRESHOLD: csr_ff.fragment_threshold <= csr_write_data[15:0];
            rtpfu_pkg::CSR_MAX_PACKET:     csr_ff.max_packet_bytes   <= csr_write_data[15:0];
            rtpfu_pkg::CSR_PAYLOAD_TYPE:   csr_ff.payload_type       <= csr_write_data[6:0];
            rtpfu_pkg::CSR_SSRC:           csr_ff.ssrc_value         <= csr_write_data;
            default: ;
         endcase
      end
   end

   rtpfu_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr      (csr_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (push_cmd)
   );

   rtpfu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   rtpfu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr_ff),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== bench/h264_rtp_fua_packetizer_tb.sv =====
// Testbench for the H.264 RTP packetizer: predicts the RTP byte stream and checks each byte.
`timescale 1ns / 1ps

module h264_rtp_fua_packetizer_tb;

   localparam int SETTLE_CYCLES  = 100;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_BYTES    = 12;
   localparam int MAX_PRINTS     = 40;

   typedef struct {
      logic [7:0]  data;
      logic        first;
      logic        last;
      logic [15:0] length;
      logic [31:0] ts;
   } nal_item_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } rtp_beat_type;

   logic clock = 1'b0;
   logic reset;
   logic        csr_write_en;
   logic [1:0]  csr_index;
   logic [31:0] csr_write_data;

   rtpfu_req_if req_chan ();
   rtpfu_rsp_if rsp_chan ();

   h264_rtp_fua_packetizer u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // packetizer state as the checker sees it
   logic [15:0] cfg_threshold;
   logic [15:0] cfg_max_pkt;
   logic [6:0]  cfg_pt;
   logic [31:0] cfg_ssrc;
   logic [15:0] seq_no;
   logic        in_fu_mode;
   logic [7:0]  nal_header;
   logic [15:0] nal_left;
   logic [15:0] frag_fill;
   logic        fu_start_due;
   logic [31:0] nal_ts;

   rtp_beat_type rtp_bytes_due[$];

   int  error_count;
   int  bytes_taken;
   int  bytes_checked;
   int  packets_seen;
   int  settings_used;
   int  quiet_cycles;
   bit  steady;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTS) $display("MISMATCH: %s", msg);
      error_count++;
   endtask

   function automatic void queue_rtp_byte(input logic [7:0] data, input logic last);
      rtp_beat_type beat;
      beat.data = data;
      beat.last = last;
      rtp_bytes_due = {rtp_bytes_due, beat};
   endfunction

   function automatic void queue_rtp_header();
      seq_no = seq_no + 16'd1;
      queue_rtp_byte(rtpfu_pkg::RTP_VERSION_BYTE, 1'b0);
      queue_rtp_byte({1'b0, cfg_pt}, 1'b0);
      queue_rtp_byte(seq_no[15:8], 1'b0);
      queue_rtp_byte(seq_no[7:0], 1'b0);
      queue_rtp_byte(nal_ts[31:24], 1'b0);
      queue_rtp_byte(nal_ts[23:16], 1'b0);
      queue_rtp_byte(nal_ts[15:8], 1'b0);
      queue_rtp_byte(nal_ts[7:0], 1'b0);
      queue_rtp_byte(cfg_ssrc[31:24], 1'b0);
      queue_rtp_byte(cfg_ssrc[23:16], 1'b0);
      queue_rtp_byte(cfg_ssrc[15:8], 1'b0);
      queue_rtp_byte(cfg_ssrc[7:0], 1'b0);
   endfunction

   // Returns 1 when the byte belongs to a NAL, 0 when the block drops it.
   function automatic bit packetize_byte(input nal_item_type item);
      logic [15:0] len;
      logic [15:0] pay_max;
      logic [15:0] left_before;
      logic        at_end;
      logic [7:0]  fu_hdr;
      pay_max = (cfg_max_pkt > rtpfu_pkg::FU_OVERHEAD) ?
                cfg_max_pkt - rtpfu_pkg::FU_OVERHEAD : 16'd1;
      if (item.first) begin
         len = (item.length == 16'd0) ? 16'd1 : item.length;
         in_fu_mode = (len >= cfg_threshold);
         nal_header = item.data;
         nal_ts = item.ts;
         nal_left = len - 16'd1;
         frag_fill = 16'd0;
         fu_start_due = 1'b1;
         at_end = (nal_left == 16'd0) || item.last;
         if (at_end) nal_left = 16'd0;
         if (!in_fu_mode) begin
            queue_rtp_header();
            queue_rtp_byte(item.data, at_end);
         end
         return 1'b1;
      end
      if (nal_left == 16'd0) return 1'b0;
      left_before = nal_left;
      at_end = (left_before == 16'd1) || item.last;
      nal_left = at_end ? 16'd0 : left_before - 16'd1;
      if (!in_fu_mode) begin
         queue_rtp_byte(item.data, at_end);
         return 1'b1;
      end
      if (frag_fill == 16'd0) begin
         fu_hdr = nal_header & rtpfu_pkg::NAL_TYPE_MASK;
         if (fu_start_due) fu_hdr = fu_hdr | rtpfu_pkg::FU_START_BIT;
         // E bit follows the announced length, not an early last_of_nal
         if (left_before <= pay_max) fu_hdr = fu_hdr | rtpfu_pkg::FU_END_BIT;
         fu_start_due = 1'b0;
         queue_rtp_header();
         queue_rtp_byte((nal_header & rtpfu_pkg::NRI_F_MASK) | {3'b000, rtpfu_pkg::FU_A_TYPE},
                        1'b0);
         queue_rtp_byte(fu_hdr, 1'b0);
      end
      frag_fill = frag_fill + 16'd1;
      if (frag_fill >= pay_max || at_end) begin
         frag_fill = 16'd0;
         queue_rtp_byte(item.data, 1'b1);
      end else begin
         queue_rtp_byte(item.data, 1'b0);
      end
      return 1'b1;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance with valid high.
   task automatic send_byte(input logic [7:0] data, input bit first, input bit last,
                            input logic [15:0] length, input logic [31:0] ts);
      nal_item_type item;
      item.data = data;
      item.first = first;
      item.last = last;
      item.length = length;
      item.ts = ts;
      while (!steady && $urandom_range(99) < 38) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.nal_byte     <= data;
      req_chan.first_of_nal <= first;
      req_chan.last_of_nal  <= last;
      req_chan.nal_length   <= length;
      req_chan.time_stamp   <= ts;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (packetize_byte(item)) bytes_taken++;
      @(negedge clock);
   endtask

   // count bytes of one NAL; header carries len_field; last_of_nal on the final byte if asked
   task automatic send_nal(input logic [7:0] header, input logic [15:0] len_field,
                           input int count, input bit mark_last, input logic [31:0] ts);
      for (int i = 0; i < count; i++) begin
         if (i == 0)
            send_byte(header, 1'b1, mark_last && count == 1, len_field, ts);
         else
            send_byte(8'($urandom_range(255)), 1'b0, mark_last && i == count - 1,
                      16'($urandom_range(16'hFFFF)), $urandom);
      end
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (rtp_bytes_due.size() != 0) @(posedge clock);
      // give a stray extra byte time to show up before moving on
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_config(input logic [15:0] threshold, input logic [15:0] max_pkt,
                             input logic [6:0] pt, input logic [31:0] ssrc);
      csr_write_en   <= 1'b1;
      csr_index      <= rtpfu_pkg::CSR_FRAG_THRESHOLD;
      csr_write_data <= {16'h0000, threshold};
      @(negedge clock);
      csr_index      <= rtpfu_pkg::CSR_MAX_PACKET;
      csr_write_data <= {16'h0000, max_pkt};
      @(negedge clock);
      csr_index      <= rtpfu_pkg::CSR_PAYLOAD_TYPE;
      csr_write_data <= {25'h0, pt};
      @(negedge clock);
      csr_index      <= rtpfu_pkg::CSR_SSRC;
      csr_write_data <= ssrc;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      cfg_threshold = threshold;
      cfg_max_pkt   = max_pkt;
      cfg_pt        = pt;
      cfg_ssrc      = ssrc;
      settings_used++;
   endtask

   // reset register values: single NALs, one-byte and zero-length NALs, stray byte, NAL cut short
   task automatic test_single_nal_defaults();
      send_nal(8'hFF, 16'd1, 1, 1'b1, 32'hFFFF_FFFF);
      send_nal(8'h00, 16'd0, 1, 1'b0, 32'h0000_0000);
      send_byte(8'hA5, 1'b0, 1'b0, 16'd7, 32'h1234_5678);
      send_nal(8'h65, 16'd3, 3, 1'b1, 32'h0102_0304);
      send_nal(8'h41, 16'd10, 2, 1'b0, 32'h8000_0001);
      send_nal(8'h21, 16'd2, 2, 1'b0, 32'h7FFF_FFFE);
      wait_drained();
   endtask

   // FU-A with start and end bits in one fragment, header-only fragmented NAL
   task automatic test_fu_a_edges();
      set_config(16'd16, 16'hFFFF, 7'h7F, 32'hFFFF_FFFF);
      send_nal(8'h7C, 16'd100, 3, 1'b1, 32'hDEAD_BEEF);
      send_nal(8'hE5, 16'd16, 1, 1'b1, 32'h0000_FFFF);
      send_byte(8'h5A, 1'b0, 1'b1, 16'd0, 32'h0);
      wait_drained();
   endtask

   // packet limit not above the FU-A overhead: one payload byte per fragment
   task automatic test_one_byte_fragments();
      set_config(16'd16, 16'd14, 7'h00, 32'h0000_0000);
      send_nal(8'h65, 16'hFFFF, 4, 1'b1, 32'h5555_AAAA);
      send_nal(8'h61, 16'd20, 3, 1'b0, 32'hAAAA_5555);
      send_nal(8'h06, 16'd2, 2, 1'b1, 32'h0F0F_0F0F);
      wait_drained();
   endtask

   task automatic test_random_streams();
      int   phase_start;
      int   pick;
      int   len;
      int   count;
      logic [15:0] len_field;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_config(16'd16, 16'd16, 7'h00, 32'h0000_0000);
            1: set_config(16'hFFFF, 16'hFFFF, 7'h7F, 32'hFFFF_FFFF);
            default: set_config(16'($urandom_range(16, 48)), 16'($urandom_range(15, 60)),
                                7'($urandom_range(127)), $urandom);
         endcase
         steady = (phase == 3);
         phase_start = bytes_taken;
         while (bytes_taken - phase_start < PHASE_BYTES) begin
            pick = $urandom_range(99);
            len = ($urandom_range(99) < 6) ? $urandom_range(50, 100) : $urandom_range(1, 40);
            if (pick < 68) begin
               send_nal(8'($urandom_range(255)), 16'(len), len, 1'($urandom_range(1)),
                        $urandom);
            end else if (pick < 78) begin
               // announced length longer than what arrives
               len_field = 16'(len + $urandom_range(1, 16'hFFFF - len));
               send_nal(8'($urandom_range(255)), len_field, $urandom_range(1, len), 1'b1,
                        $urandom);
            end else if (pick < 86) begin
               // abandoned: the next NAL starts before this one is complete
               count = $urandom_range(1, len);
               send_nal(8'($urandom_range(255)), 16'(len + 1), count, 1'b0, $urandom);
            end else if (pick < 92) begin
               // trailing bytes past the announced length are dropped
               send_nal(8'($urandom_range(255)), 16'(len), len + $urandom_range(1, 3), 1'b1,
                        $urandom);
            end else if (pick < 95) begin
               send_nal(8'($urandom_range(255)), 16'd0, 1, 1'($urandom_range(1)), $urandom);
            end else begin
               repeat ($urandom_range(1, 3))
                  send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)),
                            16'($urandom_range(16'hFFFF)), $urandom);
            end
         end
         wait_drained();
         steady = 1'b0;
      end
   endtask

   // output side: random back-pressure, sampled at the rising edge
   always @(negedge clock) begin
      rsp_chan.ready <= steady || ($urandom_range(99) >= 38);
   end

   always @(posedge clock) begin
      rtp_beat_type beat;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (rtp_bytes_due.size() == 0) begin
            report_mismatch($sformatf("unexpected RTP byte %h end %b",
                                      rsp_chan.out_byte, rsp_chan.packet_end));
         end else begin
            beat = rtp_bytes_due.pop_front();
            if (rsp_chan.out_byte !== beat.data)
               report_mismatch($sformatf("RTP byte %0d: out_byte %h, expected %h",
                                         bytes_checked, rsp_chan.out_byte, beat.data));
            if (rsp_chan.packet_end !== beat.last)
               report_mismatch($sformatf("RTP byte %0d: packet_end %b, expected %b",
                                         bytes_checked, rsp_chan.packet_end, beat.last));
            if (beat.last) packets_seen++;
         end
         bytes_checked++;
      end
   end

   // watchdog: cycles without any transaction on either channel
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("h264_rtp_fua_packetizer_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                 = 1'b1;
      csr_write_en          = 1'b0;
      csr_index             = rtpfu_pkg::CSR_FRAG_THRESHOLD;
      csr_write_data        = 32'h0;
      req_chan.valid        = 1'b0;
      req_chan.nal_byte     = 8'h00;
      req_chan.first_of_nal = 1'b0;
      req_chan.last_of_nal  = 1'b0;
      req_chan.nal_length   = 16'h0;
      req_chan.time_stamp   = 32'h0;
      rsp_chan.ready        = 1'b0;
      cfg_threshold = rtpfu_pkg::RESET_THRESHOLD;
      cfg_max_pkt   = rtpfu_pkg::RESET_MAX_PKT;
      cfg_pt        = rtpfu_pkg::RESET_PT;
      cfg_ssrc      = 32'h0;
      seq_no        = 16'h0;
      in_fu_mode    = 1'b0;
      nal_header    = 8'h00;
      nal_left      = 16'h0;
      frag_fill     = 16'h0;
      fu_start_due  = 1'b1;
      nal_ts        = 32'h0;
      error_count   = 0;
      bytes_taken   = 0;
      bytes_checked = 0;
      packets_seen  = 0;
      settings_used = 1;
      quiet_cycles  = 0;
      steady        = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_nal_defaults();
      test_fu_a_edges();
      test_one_byte_fragments();
      test_random_streams();

      $display("Coverage: %0d NAL bytes sent into %0d register settings,", bytes_taken,
               settings_used);
      $display("          %0d RTP bytes in %0d packets compared.", bytes_checked,
               packets_seen);
      if (error_count == 0) begin
         $display("h264_rtp_fua_packetizer_tb OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("h264_rtp_fua_packetizer_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/rtpfu_pkg.sv
hw/rtl/rtpfu_if.sv
hw/rtl/rtpfu_front.sv
hw/rtl/rtpfu_queue.sv
hw/rtl/rtpfu_back.sv
hw/rtl/h264_rtp_fua_packetizer.sv
bench/h264_rtp_fua_packetizer_tb.sv
